// ===== hw/rtl/dense_matrix_multiply_top_defines.svh =====
// assertion macros shared by the matrix multiply rtl
`ifndef DENSE_MATRIX_MULTIPLY_TOP_DEFINES_SVH
`define DENSE_MATRIX_MULTIPLY_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define DMM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DMM_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define DMM_ASSERT(lbl, clk, rst_n, prop, msg)
`define DMM_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ===== hw/rtl/dmm_pkg.sv =====
// types and constants of the matrix multiply block
package dmm_pkg;

  localparam int IDX_W   = 6;
  localparam int ELEM_W  = 16;
  localparam int PROD_W  = 2 * ELEM_W;
  localparam int SUM_W   = 38;
  localparam int SIZE_W  = 7;
  localparam int EMIT_MAX = 1 << IDX_W;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  typedef enum logic [1:0] {
    ACT_WR_A    = 2'd0,
    ACT_WR_B    = 2'd1,
    ACT_COMPUTE = 2'd2
  } action_e;

  typedef enum logic {
    SEQ_IDLE = 1'b0,
    SEQ_RUN  = 1'b1
  } seq_state_e;

  // control that travels along with each read pair
  typedef struct packed {
    logic             vld;
    logic             first_k;
    logic             last_k;
    logic             last_col;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } dmm_tag_t;

endpackage

// ===== hw/rtl/dmm_ram.sv =====
// generic single-write single-read ram with registered read data
module dmm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/dmm_seq.sv =====
// sequencer that walks columns and terms of one row of the product
`include "dense_matrix_multiply_top_defines.svh"

module dmm_seq import dmm_pkg::*; #(
  parameter int MAX_DIM = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 go_i,
  input  logic [IDX_W-1:0]                     row_i,
  input  logic [SIZE_W-1:0]                    size_i,
  output logic                                 rd_en_o,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   addr_a_o,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   addr_b_o,
  output dmm_tag_t                             tag_o,
  output logic                                 busy_o
);

  localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);
  localparam int LIMIT  = (MAX_DIM < EMIT_MAX) ? MAX_DIM : EMIT_MAX;

  seq_state_e        state_q, state_d;
  logic [IDX_W-1:0]  row_q, row_d;
  logic [IDX_W-1:0]  k_q, k_d;
  logic [IDX_W-1:0]  j_q, j_d;
  logic [SIZE_W-1:0] n_q, n_d;
  logic [SIZE_W-1:0] n_eff;
  logic              last_k, last_col;
  dmm_tag_t          tag_q, tag_d;

  // size register saturated to the usable range
  always_comb begin
    if (size_i == '0) begin
      n_eff = SIZE_W'(1);
    end else if (size_i > SIZE_W'(LIMIT)) begin
      n_eff = SIZE_W'(LIMIT);
    end else begin
      n_eff = size_i;
    end
  end

  assign last_k   = ({1'b0, k_q} == (n_q - SIZE_W'(1)));
  assign last_col = ({1'b0, j_q} == (n_q - SIZE_W'(1)));

  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    k_d     = k_q;
    j_d     = j_q;
    n_d     = n_q;
    tag_d   = '0;
    rd_en_o = 1'b0;
    unique case (state_q)
      SEQ_IDLE: begin
        if (go_i && ({1'b0, row_i} < n_eff)) begin
          row_d   = row_i;
          n_d     = n_eff;
          k_d     = '0;
          j_d     = '0;
          state_d = SEQ_RUN;
        end
      end
      SEQ_RUN: begin
        rd_en_o        = 1'b1;
        tag_d.vld      = 1'b1;
        tag_d.first_k  = (k_q == '0);
        tag_d.last_k   = last_k;
        tag_d.last_col = last_col;
        tag_d.row      = row_q;
        tag_d.col      = j_q;
        if (last_k) begin
          k_d = '0;
          j_d = j_q + IDX_W'(1);
          if (last_col) begin
            state_d = SEQ_IDLE;
          end
        end else begin
          k_d = k_q + IDX_W'(1);
        end
      end
      default: state_d = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
      tag_q   <= '0;
      k_q     <= '0;
      j_q     <= '0;
      n_q     <= SIZE_W'(1);
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      tag_q   <= tag_d;
      k_q     <= k_d;
      j_q     <= j_d;
      n_q     <= n_d;
      row_q   <= row_d;
    end
  end

  // a holds row i along k, b holds column j along k
  assign addr_a_o = ADDR_W'(row_q) * ADDR_W'(MAX_DIM) + ADDR_W'(k_q);
  assign addr_b_o = ADDR_W'(k_q) * ADDR_W'(MAX_DIM) + ADDR_W'(j_q);
  assign tag_o    = tag_q;
  assign busy_o   = (state_q == SEQ_RUN) || tag_q.vld;

  `DMM_ASSERT(a_k_in_range, clk_i, rst_ni,
    (state_q == SEQ_RUN) |-> (({1'b0, k_q} < n_q) && ({1'b0, j_q} < n_q)),
    "term or column counter beyond matrix size")
  `DMM_ASSERT(a_tag_follows_run, clk_i, rst_ni,
    tag_q.vld |-> $past(state_q == SEQ_RUN),
    "read beat tag without a running sequence")

endmodule

// ===== hw/rtl/dmm_mac.sv =====
// multiply-accumulate datapath and result register
module dmm_mac import dmm_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dmm_tag_t                 tag_i,
  input  logic signed [ELEM_W-1:0] a_i,
  input  logic signed [ELEM_W-1:0] b_i,
  output logic                     busy_o,
  output logic                     out_valid_o,
  output logic [IDX_W-1:0]         out_row_o,
  output logic [IDX_W-1:0]         out_col_o,
  output logic signed [SUM_W-1:0]  product_sum_o,
  output logic                     row_last_o
);

  logic signed [PROD_W-1:0] prod_q;
  dmm_tag_t                 tag_q;
  logic signed [SUM_W-1:0]  acc_q, acc_d;
  logic signed [SUM_W-1:0]  prod_ext;
  logic                     out_valid_q;
  logic [IDX_W-1:0]         out_row_q, out_col_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic                     row_last_q;

  assign prod_ext = SUM_W'(prod_q);
  assign acc_d    = tag_q.first_k ? prod_ext : (acc_q + prod_ext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      tag_q       <= tag_i;
      out_valid_q <= tag_q.vld && tag_q.last_k;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
    if (tag_q.vld) begin
      acc_q <= acc_d;
    end
    if (tag_q.vld && tag_q.last_k) begin
      sum_q      <= acc_d;
      out_row_q  <= tag_q.row;
      out_col_q  <= tag_q.col;
      row_last_q <= tag_q.last_col;
    end
  end

  assign busy_o        = tag_q.vld;
  assign out_valid_o   = out_valid_q;
  assign out_row_o     = out_row_q;
  assign out_col_o     = out_col_q;
  assign product_sum_o = sum_q;
  assign row_last_o    = row_last_q;

endmodule

// ===== hw/rtl/dense_matrix_multiply_top.sv =====
// dense matrix multiply: a compute beat emits row i of a*b, one element per column
// write beats never raise busy; a compute beat on row i keeps busy high until its last term
// has been accumulated; result strobes follow one per column of the row, in column order
// the mac rate is set by the single read port of each element ram
// reset clears control and sets matrix_size to 64; element rams are undefined until written
`include "dense_matrix_multiply_top_defines.svh"

module dense_matrix_multiply_top import dmm_pkg::*; #(
  parameter int MAX_DIM = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               action_i,
  input  logic [IDX_W-1:0]         row_index_i,
  input  logic [IDX_W-1:0]         col_index_i,
  input  logic signed [ELEM_W-1:0] element_value_i,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [SIZE_W-1:0]        cfg_data_i,
  output logic                     out_valid_o,
  output logic [IDX_W-1:0]         out_row_o,
  output logic [IDX_W-1:0]         out_col_o,
  output logic signed [SUM_W-1:0]  product_sum_o,
  output logic                     row_last_o
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [SIZE_W-1:0]        matrix_size_q;
  logic                     accept;
  logic                     in_store;
  logic                     we_a, we_b, go;
  logic [ADDR_W-1:0]        waddr;
  logic                     rd_en;
  logic [ADDR_W-1:0]        addr_a, addr_b;
  logic [ELEM_W-1:0]        rdata_a, rdata_b;
  dmm_tag_t                 tag;
  logic                     seq_busy, mac_busy;

  assign accept      = start && !busy;
  assign busy        = seq_busy || mac_busy;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matrix_size_q <= SIZE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      matrix_size_q <= cfg_data_i;
    end
  end

  assign in_store = (32'(row_index_i) < MAX_DIM) && (32'(col_index_i) < MAX_DIM);
  assign waddr    = ADDR_W'(row_index_i) * ADDR_W'(MAX_DIM) + ADDR_W'(col_index_i);

  always_comb begin
    we_a = 1'b0;
    we_b = 1'b0;
    go   = 1'b0;
    unique case (action_e'(action_i))
      ACT_WR_A:    we_a = accept && in_store;
      ACT_WR_B:    we_b = accept && in_store;
      ACT_COMPUTE: go   = accept;
      default: begin
        we_a = 1'b0;
      end
    endcase
  end

  dmm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (element_value_i),
    .re_i    (rd_en),
    .raddr_i (addr_a),
    .rdata_o (rdata_a)
  );

  dmm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr),
    .wdata_i (element_value_i),
    .re_i    (rd_en),
    .raddr_i (addr_b),
    .rdata_o (rdata_b)
  );

  dmm_seq #(.MAX_DIM(MAX_DIM)) u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .go_i     (go),
    .row_i    (row_index_i),
    .size_i   (matrix_size_q),
    .rd_en_o  (rd_en),
    .addr_a_o (addr_a),
    .addr_b_o (addr_b),
    .tag_o    (tag),
    .busy_o   (seq_busy)
  );

  dmm_mac u_mac (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tag_i         (tag),
    .a_i           (rdata_a),
    .b_i           (rdata_b),
    .busy_o        (mac_busy),
    .out_valid_o   (out_valid_o),
    .out_row_o     (out_row_o),
    .out_col_o     (out_col_o),
    .product_sum_o (product_sum_o),
    .row_last_o    (row_last_o)
  );

  `DMM_ASSERT(a_last_then_gap, clk_i, rst_ni,
    (out_valid_o && row_last_o) |=> !out_valid_o,
    "result beat right after the last beat of a row")
  `DMM_ASSERT(a_row_pending_busy, clk_i, rst_ni,
    (out_valid_o && !row_last_o) |-> busy,
    "row not finished but block reports idle")
  `DMM_ASSERT(a_busy_from_start, clk_i, rst_ni,
    $rose(busy) |-> $past(start),
    "busy rose without a command beat")
  `DMM_ASSERT_NEVER(a_no_write_while_busy, clk_i, rst_ni,
    (we_a || we_b) && busy,
    "element write while a row is being computed")

endmodule
